[rtl/core/bcg_pkg.sv]
package bcg_pkg;

  localparam int unsigned GridSideDef  = 64;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned CoordBits    = 6;
  localparam int unsigned ObsBits      = 8;
  localparam int unsigned OutBits      = FracBitsDef + 1;
  localparam int unsigned NumPairs     = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } state_e;

endpackage

[rtl/core/bcg_div.sv]
module bcg_div #(
  parameter int unsigned COUNT_BITS = bcg_pkg::CountBitsDef,
  parameter int unsigned FRAC_BITS  = bcg_pkg::FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [COUNT_BITS:0]      num_i,
  input  logic [COUNT_BITS:0]      den_i,
  output logic                     done_o,
  output logic [FRAC_BITS:0]       quo_o
);
  import bcg_pkg::*;

  localparam int unsigned DW = COUNT_BITS + 1;
  localparam int unsigned NW = DW + FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, num_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   trial;
  logic [NW-1:0] dividend;

  assign dividend = ({{(FRAC_BITS+1){1'b0}}, num_i} << FRAC_BITS)
                  + {{(FRAC_BITS+1){1'b0}}, (den_i >> 1)};
  assign trial = {rem_q[DW-1:0], num_q[NW-1]};

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = dividend;
      quo_d  = '0;
      rem_d  = '0;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = num_q << 1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = (den_q == '0) ? '0 : quo_q[FRAC_BITS:0];

endmodule

[rtl/core/bcg_store.sv]
module bcg_store #(
  parameter int unsigned ADDR_BITS = 12,
  parameter int unsigned DATA_BITS = 2 * bcg_pkg::CountBitsDef * bcg_pkg::NumPairs
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_BITS-1:0]      waddr_i,
  input  logic [DATA_BITS-1:0]      wdata_i,
  input  logic [ADDR_BITS-1:0]      raddr_i,
  output logic [DATA_BITS-1:0]      rdata_o
);
  import bcg_pkg::*;

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/core/beta_count_grid_estimator.sv]
// sequence: a start transfer reads the cell, updates its counters, then the six quotients
// share one serial divider of COUNT_BITS + FRAC_BITS + 2 steps
// handshake: one update at a time; a new start is taken in the cycle done_o is high
// results: done_o strobes one cycle with all six fields; the receiver cannot stall
// reset: asynchronous active low, then a clearing pass over all GRID_SIDE*GRID_SIDE cells
// writes every counter to one while busy is high
module beta_count_grid_estimator #(
  parameter int unsigned GRID_SIDE  = bcg_pkg::GridSideDef,
  parameter int unsigned COUNT_BITS = bcg_pkg::CountBitsDef,
  parameter int unsigned FRAC_BITS  = bcg_pkg::FracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [bcg_pkg::CoordBits-1:0]   cell_x_i,
  input  logic [bcg_pkg::CoordBits-1:0]   cell_y_i,
  input  logic [bcg_pkg::ObsBits-1:0]     free_to_occupied_i,
  input  logic [bcg_pkg::ObsBits-1:0]     free_to_free_i,
  input  logic [bcg_pkg::ObsBits-1:0]     occupied_to_free_i,
  input  logic [bcg_pkg::ObsBits-1:0]     occupied_to_occupied_i,
  input  logic [bcg_pkg::ObsBits-1:0]     init_occupied_i,
  input  logic [bcg_pkg::ObsBits-1:0]     init_free_i,
  output logic                            done_o,
  output logic [FRAC_BITS:0]              entry_mode_o,
  output logic [FRAC_BITS:0]              entry_mean_o,
  output logic [FRAC_BITS:0]              exit_mode_o,
  output logic [FRAC_BITS:0]              exit_mean_o,
  output logic [FRAC_BITS:0]              init_mode_o,
  output logic [FRAC_BITS:0]              init_mean_o
);
  import bcg_pkg::*;

  localparam int unsigned SideBits = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
  localparam int unsigned AddrBits = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int unsigned CellCnt  = GRID_SIDE * GRID_SIDE;
  localparam int unsigned CW       = COUNT_BITS;
  localparam int unsigned ModBits  = CoordBits + SideBits + 1;
  localparam logic [CW-1:0] CntMax = '1;
  localparam logic [CW-1:0] CntOne = CW'(1);

  state_e state_q, state_d;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic [AddrBits:0]   clr_q, clr_d;
  logic [ObsBits-1:0]  obs_q [2*NumPairs];
  logic [1:0]          pair_q, pair_d;
  logic                half_q, half_d;
  logic [CW-1:0]       a_q [NumPairs];
  logic [CW-1:0]       b_q [NumPairs];
  logic [FRAC_BITS:0]  res_q [2*NumPairs];
  logic                done_q, done_d;
  logic                we;
  logic [AddrBits-1:0] waddr;
  logic [2*CW*NumPairs-1:0] wdata;
  logic [2*CW*NumPairs-1:0] rdata;
  logic [CW-1:0]       new_a [NumPairs];
  logic [CW-1:0]       new_b [NumPairs];
  logic                div_start;
  logic                div_done;
  logic [CW:0]         num, den;
  logic [FRAC_BITS:0]  quo;
  logic [CW-1:0]       ca, cb;
  logic                uniform;
  logic [SideBits-1:0] xs, ys;

  function automatic logic [CW-1:0] sat_add(logic [CW-1:0] c, logic [ObsBits-1:0] o);
    logic [CW:0] s;
    s = {1'b0, c} + (CW+1)'(o);
    return s[CW] ? CntMax : s[CW-1:0];
  endfunction

  // coordinate modulo the grid side by shifted compare and subtract
  function automatic logic [SideBits-1:0] side_mod(logic [CoordBits-1:0] v);
    logic [ModBits-1:0] r;
    r = ModBits'(v);
    for (int k = CoordBits - 1; k >= 0; k--) begin
      if (r >= (ModBits'(GRID_SIDE) << k)) begin
        r = r - (ModBits'(GRID_SIDE) << k);
      end
    end
    return SideBits'(r);
  endfunction

  assign xs = side_mod(cell_x_i);
  assign ys = side_mod(cell_y_i);

  for (genvar p = 0; p < NumPairs; p++) begin : g_pair
    assign new_a[p] = sat_add(rdata[2*CW*p+CW +: CW], obs_q[2*p]);
    assign new_b[p] = sat_add(rdata[2*CW*p +: CW], obs_q[2*p+1]);
    assign wdata[2*CW*p +: 2*CW] = (state_q == ST_CLEAR) ? {CntOne, CntOne}
                                                          : {new_a[p], new_b[p]};
  end

  bcg_store #(.ADDR_BITS(AddrBits), .DATA_BITS(2*CW*NumPairs)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  assign ca = a_q[pair_q];
  assign cb = b_q[pair_q];
  assign uniform = (ca == CntOne) && (cb == CntOne);
  assign num = half_q ? {1'b0, ca} : ({1'b0, ca} - (CW+1)'(1));
  assign den = half_q ? ({1'b0, ca} + {1'b0, cb})
                      : ({1'b0, ca} + {1'b0, cb} - (CW+1)'(2));

  bcg_div #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    clr_d     = clr_q;
    pair_d    = pair_q;
    half_d    = half_q;
    done_d    = 1'b0;
    we        = 1'b0;
    waddr     = addr_q;
    div_start = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q[AddrBits-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (AddrBits+1)'(CellCnt - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          addr_d  = AddrBits'(ys * GRID_SIDE + xs);
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_UPDATE;
      ST_UPDATE: begin
        we        = 1'b1;
        pair_d    = '0;
        half_d    = 1'b0;
        state_d   = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        div_start = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (div_done) begin
          if (half_q) begin
            half_d = 1'b0;
            if (pair_q == 2'(NumPairs - 1)) begin
              done_d  = 1'b1;
              state_d = ST_IDLE;
            end else begin
              pair_d  = pair_q + 1'b1;
              state_d = ST_DIVIDE;
            end
          end else begin
            half_d  = 1'b1;
            state_d = ST_DIVIDE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
      pair_q  <= '0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      pair_q  <= pair_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    if (state_q == ST_IDLE && start) begin
      obs_q[0] <= free_to_occupied_i;
      obs_q[1] <= free_to_free_i;
      obs_q[2] <= occupied_to_free_i;
      obs_q[3] <= occupied_to_occupied_i;
      obs_q[4] <= init_occupied_i;
      obs_q[5] <= init_free_i;
    end
    if (state_q == ST_UPDATE) begin
      for (int p = 0; p < NumPairs; p++) begin
        a_q[p] <= new_a[p];
        b_q[p] <= new_b[p];
      end
    end
    if (state_q == ST_DONE && div_done) begin
      if (!half_q && uniform) begin
        res_q[{pair_q, 1'b0}] <= (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
      end else begin
        res_q[{pair_q, half_q}] <= quo;
      end
    end
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign entry_mode_o = res_q[0];
  assign entry_mean_o = res_q[1];
  assign exit_mode_o  = res_q[2];
  assign exit_mean_o  = res_q[3];
  assign init_mode_o  = res_q[4];
  assign init_mean_o  = res_q[5];

endmodule

[rtl/core/bcg_checker.sv]
module bcg_checker #(
  parameter int unsigned FRAC_BITS = bcg_pkg::FracBitsDef
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 start,
  input logic                 busy,
  input logic                 done_o,
  input logic [FRAC_BITS:0]   entry_mean_o,
  input logic [FRAC_BITS:0]   exit_mean_o,
  input logic [FRAC_BITS:0]   init_mean_o
);
  import bcg_pkg::*;

  localparam logic [FRAC_BITS:0] One = (FRAC_BITS+1)'(1) << FRAC_BITS;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("no busy after transfer");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy with done");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("done without work");
  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (entry_mean_o <= One && exit_mean_o <= One && init_mean_o <= One))
    else $error("mean above one");

endmodule

bind beta_count_grid_estimator bcg_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .entry_mean_o (entry_mean_o),
  .exit_mean_o  (exit_mean_o),
  .init_mean_o  (init_mean_o)
);

[test/beta_count_grid_estimator_tb.sv]
`timescale 1ns / 1ps

module beta_count_grid_estimator_tb;
  import bcg_pkg::*;

  localparam int unsigned Side = 64;
  localparam int unsigned Cells = Side * Side;
  localparam longint unsigned CountMax = 65535;
  localparam int unsigned Frac = 16;
  localparam longint unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    logic [OutBits-1:0] entry_mode;
    logic [OutBits-1:0] entry_mean;
    logic [OutBits-1:0] exit_mode;
    logic [OutBits-1:0] exit_mean;
    logic [OutBits-1:0] init_mode;
    logic [OutBits-1:0] init_mean;
  } estimate_t;

  logic clk_i, rst_ni, start, busy, done_o;
  logic [CoordBits-1:0] cell_x_i, cell_y_i;
  logic [ObsBits-1:0] free_to_occupied_i, free_to_free_i, occupied_to_free_i;
  logic [ObsBits-1:0] occupied_to_occupied_i, init_occupied_i, init_free_i;
  logic [OutBits-1:0] entry_mode_o, entry_mean_o, exit_mode_o, exit_mean_o;
  logic [OutBits-1:0] init_mode_o, init_mean_o;

  // grid counters: [pair*2 + 0] alpha, [pair*2 + 1] beta
  logic [15:0] grid_counts [6][Cells];
  estimate_t pending_estimates [$];
  int error_count = 0;
  longint unsigned cycle_count = 0;
  bit gaps_on = 1;

  beta_count_grid_estimator dut (.*);

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [OutBits-1:0] q16_div(longint unsigned num, longint unsigned den);
    if (den == 0) return '0;
    return OutBits'(((num << Frac) + (den >> 1)) / den);
  endfunction

  function automatic logic [OutBits-1:0] pair_mode(longint unsigned a, longint unsigned b);
    if (a == 1 && b == 1) return OutBits'(1 << (Frac - 1));
    if (a == 0) return '0;
    return q16_div(a - 1, a + b - 2);
  endfunction

  function automatic estimate_t update_cell(logic [5:0] x, logic [5:0] y,
                                            logic [7:0] obs [6]);
    int idx;
    longint unsigned s, a, b;
    estimate_t e;
    logic [OutBits-1:0] modes [3], means [3];
    idx = int'(y) * Side + int'(x);
    for (int k = 0; k < 6; k++) begin
      s = grid_counts[k][idx] + obs[k];
      grid_counts[k][idx] = (s > CountMax) ? 16'(CountMax) : 16'(s);
    end
    for (int p = 0; p < 3; p++) begin
      a = grid_counts[2*p][idx];
      b = grid_counts[2*p+1][idx];
      modes[p] = pair_mode(a, b);
      means[p] = q16_div(a, a + b);
    end
    e.entry_mode = modes[0]; e.entry_mean = means[0];
    e.exit_mode = modes[1]; e.exit_mean = means[1];
    e.init_mode = modes[2]; e.init_mean = means[2];
    return e;
  endfunction

  task automatic send_obs(logic [5:0] x, logic [5:0] y, logic [7:0] obs [6]);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    cell_x_i <= x; cell_y_i <= y;
    free_to_occupied_i <= obs[0]; free_to_free_i <= obs[1];
    occupied_to_free_i <= obs[2]; occupied_to_occupied_i <= obs[3];
    init_occupied_i <= obs[4]; init_free_i <= obs[5];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_estimates.insert(pending_estimates.size(), update_cell(x, y, obs));
  endtask

  always @(posedge clk_i) begin
    estimate_t exp_e;
    if (rst_ni && done_o) begin
      if (pending_estimates.size() == 0) begin
        $error("transfer with no expected result");
        error_count++;
      end else begin
        exp_e = pending_estimates.pop_front();
        if (entry_mode_o !== exp_e.entry_mode) begin
          $error("entry_mode exp %0d got %0d", exp_e.entry_mode, entry_mode_o); error_count++;
        end
        if (entry_mean_o !== exp_e.entry_mean) begin
          $error("entry_mean exp %0d got %0d", exp_e.entry_mean, entry_mean_o); error_count++;
        end
        if (exit_mode_o !== exp_e.exit_mode) begin
          $error("exit_mode exp %0d got %0d", exp_e.exit_mode, exit_mode_o); error_count++;
        end
        if (exit_mean_o !== exp_e.exit_mean) begin
          $error("exit_mean exp %0d got %0d", exp_e.exit_mean, exit_mean_o); error_count++;
        end
        if (init_mode_o !== exp_e.init_mode) begin
          $error("init_mode exp %0d got %0d", exp_e.init_mode, init_mode_o); error_count++;
        end
        if (init_mean_o !== exp_e.init_mean) begin
          $error("init_mean exp %0d got %0d", exp_e.init_mean, init_mean_o); error_count++;
        end
      end
    end
  end

  task automatic fill_obs(output logic [7:0] obs [6], input int unsigned hi);
    for (int k = 0; k < 6; k++) obs[k] = 8'($urandom_range(0, hi));
  endtask

  task automatic test_directed();
    logic [7:0] obs [6];
    obs = '{default: 8'd0};
    send_obs(6'd0, 6'd0, obs);            // uniform prior query
    send_obs(6'd63, 6'd63, obs);
    obs = '{default: 8'hff};
    send_obs(6'd63, 6'd0, obs);
    obs = '{8'hff, 8'd0, 8'd0, 8'hff, 8'd1, 8'd0};
    send_obs(6'd0, 6'd63, obs);
    obs = '{8'd0, 8'd1, 8'd2, 8'd0, 8'd0, 8'd3};
    send_obs(6'd21, 6'd42, obs);
    obs = '{8'haa, 8'h55, 8'h55, 8'haa, 8'hf0, 8'h0f};
    send_obs(6'd42, 6'd21, obs);
    // drive one cell into saturation
    for (int i = 0; i < 260; i++) begin
      obs = '{default: 8'hff};
      if (i % 3 == 0) obs[1] = 8'd0;
      send_obs(6'd5, 6'd9, obs);
    end
    obs = '{default: 8'd0};
    send_obs(6'd5, 6'd9, obs);
  endtask

  task automatic test_random(int n);
    logic [7:0] obs [6];
    logic [5:0] x, y;
    for (int i = 0; i < n; i++) begin
      // hot cells accumulate deep counts; the rest cover the whole grid
      if ($urandom_range(0, 1)) begin
        x = 6'($urandom_range(0, 3)); y = 6'($urandom_range(60, 63));
      end else begin
        x = 6'($urandom); y = 6'($urandom);
      end
      case ($urandom_range(0, 3))
        0: obs = '{default: 8'd0};
        1: fill_obs(obs, 3);
        default: fill_obs(obs, 255);
      endcase
      send_obs(x, y, obs);
    end
  endtask

  initial begin
    int wait_cycles;
    rst_ni = 1'b0; start = 1'b0;
    cell_x_i = '0; cell_y_i = '0;
    free_to_occupied_i = '0; free_to_free_i = '0; occupied_to_free_i = '0;
    occupied_to_occupied_i = '0; init_occupied_i = '0; init_free_i = '0;
    for (int k = 0; k < 6; k++)
      for (int c = 0; c < Cells; c++) grid_counts[k][c] = 16'd1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1000);
    gaps_on = 0;
    test_random(130);
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_estimates.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (150) @(posedge clk_i);
    if (error_count == 0 && pending_estimates.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
